### rtl/mlfq_slice_scheduler_defines.svh
// ----------------------------------------------------------------------------
// mlfq_slice_scheduler_defines
// Assertion macros shared by the scheduler RTL. Each check is clocked on clk
// and switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MLFQ_SLICE_SCHEDULER_DEFINES_SVH
`define MLFQ_SLICE_SCHEDULER_DEFINES_SVH

// Same-cycle implication.
`define MLFQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mlfq: same-cycle check failed");

// Next-cycle implication.
`define MLFQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mlfq: next-cycle check failed");

`endif

### rtl/mlfq_pkg.sv
// ----------------------------------------------------------------------------
// mlfq_pkg
// Constants, codes and record types of the multilevel feedback queue
// scheduler.
// ----------------------------------------------------------------------------
package mlfq_pkg;

  localparam int MAX_PROCS  = 64;
  localparam int PROC_IDX_W = $clog2(MAX_PROCS);
  localparam int CNT_W      = $clog2(MAX_PROCS + 1);
  localparam int NUM_LEVELS = 3;
  localparam int LVL_W      = 2;
  localparam int FIFO_DEPTH = NUM_LEVELS * MAX_PROCS;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int PID_W   = 6;
  localparam int TIME_W  = 31;
  localparam int BURST_W = 16;
  localparam int Q_W     = 16;
  localparam int SPAN_W  = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [LVL_W-1:0]  LAST_LEVEL = 2'd2;
  localparam logic [TIME_W-1:0] CLOCK_MAX  = 31'h7FFF_FFFF;
  localparam logic [CNT_W-1:0]  FIFO_FULL  = CNT_W'(MAX_PROCS);

  localparam logic [Q_W-1:0] Q0_RESET = 16'd2;
  localparam logic [Q_W-1:0] Q1_RESET = 16'd4;
  localparam logic [Q_W-1:0] Q2_RESET = 16'd8;

  typedef enum logic {
    CMD_ADMIT = 1'b0,
    CMD_RUN   = 1'b1
  } cmd_e_t;

  typedef enum logic [1:0] {
    STAT_ADMITTED = 2'd0,
    STAT_RAN      = 2'd1,
    STAT_EMPTY    = 2'd2
  } status_e_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUANTUM0 = 2'd0,
    REG_QUANTUM1 = 2'd1,
    REG_QUANTUM2 = 2'd2
  } cfg_reg_e_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADMIT,
    ST_FETCH,
    ST_EXEC,
    ST_FIN
  } state_e_t;

  // One process table row.
  typedef struct packed {
    logic [TIME_W-1:0]  arrival;
    logic [BURST_W-1:0] burst;
    logic [BURST_W-1:0] remaining;
    logic [TIME_W-1:0]  start;
    logic               started;
  } ptbl_entry_t;

  // Outcome of one slice, produced by the slice unit.
  typedef struct packed {
    logic [BURST_W-1:0] slice;
    logic [BURST_W-1:0] remaining;
    logic [TIME_W-1:0]  clock_next;
    logic [TIME_W-1:0]  start;
    logic               done;
    logic [LVL_W-1:0]   next_level;
    logic [SPAN_W-1:0]  arr_plus_burst;
  } calc_res_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [PID_W-1:0]   run_pid;
    logic [BURST_W-1:0] slice_length;
    logic [BURST_W-1:0] left_time;
    logic [TIME_W-1:0]  first_start;
    logic               done_res;
    logic [TIME_W-1:0]  finish_stamp;
    logic [SPAN_W-1:0]  response_delay;
    logic [SPAN_W-1:0]  turnaround_span;
    logic [SPAN_W-1:0]  waiting_span;
    logic [LVL_W-1:0]   next_level;
  } result_t;

endpackage

### rtl/mlfq_ram.sv
// ----------------------------------------------------------------------------
// mlfq_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module mlfq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/mlfq_slice_calc.sv
// ----------------------------------------------------------------------------
// mlfq_slice_calc
// Slice arithmetic for one run: slice length, remaining service, saturating
// clock advance, first start time and the level to requeue into.
// ----------------------------------------------------------------------------
module mlfq_slice_calc (
  input  mlfq_pkg::ptbl_entry_t          entry,
  input  logic [mlfq_pkg::TIME_W-1:0]    clock_now,
  input  logic [mlfq_pkg::Q_W-1:0]       quantum,
  input  logic [mlfq_pkg::LVL_W-1:0]     level,
  output mlfq_pkg::calc_res_t            res
);
  import mlfq_pkg::*;

  logic [BURST_W-1:0] slice;
  logic [TIME_W:0]    clk_sum;

  assign slice   = (entry.remaining < quantum) ? entry.remaining : quantum;
  assign clk_sum = {1'b0, clock_now} + {{(TIME_W + 1 - BURST_W){1'b0}}, slice};

  always_comb begin
    res.slice      = slice;
    res.remaining  = entry.remaining - slice;
    res.clock_next = clk_sum[TIME_W] ? CLOCK_MAX : clk_sum[TIME_W-1:0];
    res.start      = entry.started ? entry.start : clock_now;
    res.done       = (res.remaining == '0);
    // A process whose slice equals its level's quantum drops one level, except at the bottom.
    res.next_level = ((slice == quantum) && (level < LAST_LEVEL)) ? level + 2'd1 : level;
    res.arr_plus_burst = {1'b0, entry.arrival} + {{(SPAN_W - BURST_W){1'b0}}, entry.burst};
  end

endmodule

### rtl/mlfq_slice_scheduler.sv
// Result path: an admit result is registered from the ADMIT state, a run
// result from FIN after FETCH and EXEC, and an empty-level result from IDLE.
// Flow: one item at a time; busy drops in the cycle the result shows, and
// an empty run never raises busy. The run path is set by the FIFO read, the
// dependent process table read and one stage for the times.
// Reset clears control state; memories are not cleared.
`include "mlfq_slice_scheduler_defines.svh"
// ----------------------------------------------------------------------------
// mlfq_slice_scheduler
// Three-level feedback queue scheduler with the process table and the level
// FIFOs held in synchronous RAMs.
// ----------------------------------------------------------------------------
module mlfq_slice_scheduler (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_command,
  input  logic [1:0]                        in_level,
  input  logic [mlfq_pkg::PID_W-1:0]        in_pid,
  input  logic [mlfq_pkg::TIME_W-1:0]       in_arrival_time,
  input  logic [mlfq_pkg::BURST_W-1:0]      in_burst_time,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mlfq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mlfq_pkg::Q_W-1:0]          cfg_data,
  output logic                              out_valid,
  output logic [1:0]                        out_status,
  output logic [mlfq_pkg::PID_W-1:0]        out_run_pid,
  output logic [mlfq_pkg::BURST_W-1:0]      out_slice_length,
  output logic [mlfq_pkg::BURST_W-1:0]      out_left_time,
  output logic [mlfq_pkg::TIME_W-1:0]       out_first_start,
  output logic                              out_done_res,
  output logic [mlfq_pkg::TIME_W-1:0]       out_finish_stamp,
  output logic signed [mlfq_pkg::SPAN_W-1:0] out_response_delay,
  output logic signed [mlfq_pkg::SPAN_W-1:0] out_turnaround_span,
  output logic signed [mlfq_pkg::SPAN_W-1:0] out_waiting_span,
  output logic [mlfq_pkg::LVL_W-1:0]        out_next_level
);
  import mlfq_pkg::*;

  localparam int TBL_W = $bits(ptbl_entry_t);

  state_e_t state_r, state_nxt;

  logic [LVL_W-1:0]      lvl_r;
  logic [PID_W-1:0]      pid_r;
  logic [TIME_W-1:0]     arr_r;
  logic [BURST_W-1:0]    burst_r;
  logic [PROC_IDX_W-1:0] slot_r;

  logic [PROC_IDX_W-1:0] head_r   [NUM_LEVELS];
  logic [PROC_IDX_W-1:0] head_nxt [NUM_LEVELS];
  logic [CNT_W-1:0]      cnt_r    [NUM_LEVELS];
  logic [CNT_W-1:0]      cnt_nxt  [NUM_LEVELS];
  logic [TIME_W-1:0]     clk_now_r, clk_now_nxt;
  logic [Q_W-1:0]        quant_r  [NUM_LEVELS];

  logic [BURST_W-1:0] ex_slice_r;
  logic [BURST_W-1:0] ex_rem_r;
  logic [TIME_W-1:0]  ex_start_r;
  logic               ex_done_r;
  logic [LVL_W-1:0]   ex_nl_r;
  logic [TIME_W-1:0]  ex_arr_r;
  logic [SPAN_W-1:0]  ex_apb_r;

  result_t res_r, res_nxt;
  logic    out_valid_r, out_valid_nxt;

  logic             accept;
  logic [LVL_W-1:0] in_lvl;
  logic             in_empty;

  logic                  push_en;
  logic [LVL_W-1:0]      push_lvl;
  logic [PROC_IDX_W-1:0] push_slot;
  logic [PROC_IDX_W-1:0] push_tail;

  logic                  fifo_rd_en;
  logic [FIFO_AW-1:0]    fifo_rd_addr;
  logic [PROC_IDX_W-1:0] fifo_rdata;

  logic                  tbl_wr_en;
  logic [PROC_IDX_W-1:0] tbl_wr_addr;
  ptbl_entry_t           tbl_wdata;
  logic [TBL_W-1:0]      tbl_rdata;
  ptbl_entry_t           tbl_rd;

  calc_res_t calc;

  logic [SPAN_W-1:0] resp;
  logic [SPAN_W-1:0] turn;
  logic [SPAN_W:0]   wait_wide;
  logic [SPAN_W-1:0] wait_sat;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign in_lvl    = (in_level > LAST_LEVEL) ? LAST_LEVEL : in_level;
  assign in_empty  = (cnt_r[in_lvl] == '0);
  assign tbl_rd    = ptbl_entry_t'(tbl_rdata);

  // --------------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------------
  assign fifo_rd_en   = accept && (in_command == CMD_RUN);
  assign fifo_rd_addr = {in_lvl, head_r[in_lvl]};

  mlfq_ram #(
    .DEPTH (FIFO_DEPTH),
    .WIDTH (PROC_IDX_W)
  ) u_fifo_ram (
    .clk     (clk),
    .wr_en   (push_en),
    .wr_addr ({push_lvl, push_tail}),
    .wr_data (push_slot),
    .rd_en   (fifo_rd_en),
    .rd_addr (fifo_rd_addr),
    .rd_data (fifo_rdata)
  );

  always_comb begin
    tbl_wr_en   = (state_r == ST_ADMIT) || (state_r == ST_EXEC);
    tbl_wr_addr = slot_r;
    tbl_wdata.arrival   = tbl_rd.arrival;
    tbl_wdata.burst     = tbl_rd.burst;
    tbl_wdata.remaining = calc.remaining;
    tbl_wdata.start     = calc.start;
    tbl_wdata.started   = 1'b1;
    if (state_r == ST_ADMIT) begin
      tbl_wr_addr = pid_r[PROC_IDX_W-1:0];
      tbl_wdata.arrival   = arr_r;
      tbl_wdata.burst     = burst_r;
      tbl_wdata.remaining = burst_r;
      tbl_wdata.start     = '0;
      tbl_wdata.started   = 1'b0;
    end
  end

  mlfq_ram #(
    .DEPTH (MAX_PROCS),
    .WIDTH (TBL_W)
  ) u_tbl_ram (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wdata),
    .rd_en   (state_r == ST_FETCH),
    .rd_addr (fifo_rdata),
    .rd_data (tbl_rdata)
  );

  mlfq_slice_calc u_calc (
    .entry     (tbl_rd),
    .clock_now (clk_now_r),
    .quantum   (quant_r[lvl_r]),
    .level     (lvl_r),
    .res       (calc)
  );

  // --------------------------------------------------------------------------
  // Queue pointers and clock
  // --------------------------------------------------------------------------
  always_comb begin
    push_en   = 1'b0;
    push_lvl  = lvl_r;
    push_slot = pid_r[PROC_IDX_W-1:0];
    case (state_r)
      ST_ADMIT: begin
        push_en = (cnt_r[lvl_r] != FIFO_FULL);
      end
      ST_EXEC: begin
        push_lvl  = calc.next_level;
        push_slot = slot_r;
        // Requeueing into the level just popped always finds room.
        push_en   = !calc.done &&
                    ((calc.next_level == lvl_r) || (cnt_r[calc.next_level] != FIFO_FULL));
      end
      default: begin
        push_en = 1'b0;
      end
    endcase
    // With pre-pop pointers this is the tail for both the same and another level.
    push_tail = head_r[push_lvl] + cnt_r[push_lvl][PROC_IDX_W-1:0];

    head_nxt    = head_r;
    cnt_nxt     = cnt_r;
    clk_now_nxt = clk_now_r;
    if (state_r == ST_EXEC) begin
      head_nxt[lvl_r] = head_r[lvl_r] + 1'b1;
      cnt_nxt[lvl_r]  = cnt_r[lvl_r] - 1'b1;
      clk_now_nxt     = calc.clock_next;
    end
    if (push_en) begin
      cnt_nxt[push_lvl] = cnt_nxt[push_lvl] + 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      clk_now_r   <= '0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head_r[l] <= '0;
        cnt_r[l]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      clk_now_r   <= clk_now_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quant_r[0] <= Q0_RESET;
      quant_r[1] <= Q1_RESET;
      quant_r[2] <= Q2_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_QUANTUM0: quant_r[0] <= cfg_data;
        REG_QUANTUM1: quant_r[1] <= cfg_data;
        REG_QUANTUM2: quant_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_command == CMD_ADMIT) begin
            state_nxt = ST_ADMIT;
          end else if (!in_empty) begin
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_ADMIT: state_nxt = ST_IDLE;
      ST_FETCH: state_nxt = ST_EXEC;
      ST_EXEC:  state_nxt = ST_FIN;
      ST_FIN:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Item and slice registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      lvl_r   <= in_lvl;
      pid_r   <= in_pid;
      arr_r   <= in_arrival_time;
      burst_r <= in_burst_time;
    end
    if (state_r == ST_FETCH) begin
      slot_r <= fifo_rdata;
    end
    if (state_r == ST_EXEC) begin
      ex_slice_r <= calc.slice;
      ex_rem_r   <= calc.remaining;
      ex_start_r <= calc.start;
      ex_done_r  <= calc.done;
      ex_nl_r    <= calc.next_level;
      ex_arr_r   <= tbl_rd.arrival;
      ex_apb_r   <= calc.arr_plus_burst;
    end
    res_r <= res_nxt;
  end

  // --------------------------------------------------------------------------
  // Result
  // --------------------------------------------------------------------------
  assign resp      = {1'b0, ex_start_r} - {1'b0, ex_arr_r};
  assign turn      = {1'b0, clk_now_r} - {1'b0, ex_arr_r};
  assign wait_wide = {2'b00, clk_now_r} - {1'b0, ex_apb_r};
  // Waiting time clamps at the most negative 32-bit value.
  assign wait_sat  = (wait_wide[SPAN_W] && !wait_wide[SPAN_W-1]) ?
                     {1'b1, {(SPAN_W - 1){1'b0}}} : wait_wide[SPAN_W-1:0];

  always_comb begin
    out_valid_nxt = 1'b0;
    res_nxt       = res_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_command == CMD_RUN) && in_empty) begin
          out_valid_nxt        = 1'b1;
          res_nxt              = '0;
          res_nxt.status       = STAT_EMPTY;
          res_nxt.finish_stamp = clk_now_r;
        end
      end
      ST_ADMIT: begin
        out_valid_nxt        = 1'b1;
        res_nxt              = '0;
        res_nxt.status       = STAT_ADMITTED;
        res_nxt.run_pid      = pid_r;
        res_nxt.left_time    = burst_r;
        res_nxt.finish_stamp = clk_now_r;
        res_nxt.next_level   = lvl_r;
      end
      ST_FIN: begin
        out_valid_nxt           = 1'b1;
        res_nxt                 = '0;
        res_nxt.status          = STAT_RAN;
        res_nxt.run_pid         = PID_W'(slot_r);
        res_nxt.slice_length    = ex_slice_r;
        res_nxt.left_time       = ex_rem_r;
        res_nxt.first_start     = ex_start_r;
        res_nxt.done_res        = ex_done_r;
        res_nxt.finish_stamp    = clk_now_r;
        if (ex_done_r) begin
          res_nxt.response_delay  = resp;
          res_nxt.turnaround_span = turn;
          res_nxt.waiting_span    = wait_sat;
        end else begin
          res_nxt.next_level = ex_nl_r;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_status          = res_r.status;
  assign out_run_pid         = res_r.run_pid;
  assign out_slice_length    = res_r.slice_length;
  assign out_left_time       = res_r.left_time;
  assign out_first_start     = res_r.first_start;
  assign out_done_res        = res_r.done_res;
  assign out_finish_stamp    = res_r.finish_stamp;
  assign out_response_delay  = $signed(res_r.response_delay);
  assign out_turnaround_span = $signed(res_r.turnaround_span);
  assign out_waiting_span    = $signed(res_r.waiting_span);
  assign out_next_level      = res_r.next_level;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `MLFQ_ASSERT_IMP(a_cnt_bound, 1'b1, (cnt_r[0] <= FIFO_FULL) && (cnt_r[1] <= FIFO_FULL) && (cnt_r[2] <= FIFO_FULL))
  `MLFQ_ASSERT_NXT(a_empty_reply, accept && (in_command == CMD_RUN) && in_empty, out_valid_r && (res_r.status == STAT_EMPTY))
  `MLFQ_ASSERT_IMP(a_result_idle, out_valid_r, state_r == ST_IDLE)
  `MLFQ_ASSERT_IMP(a_done_fields, out_valid_r && (res_r.status == STAT_RAN) && res_r.done_res, (res_r.left_time == '0) && (res_r.next_level == '0))

endmodule

### tb/tb_mlfq_slice_scheduler.sv
// ----------------------------------------------------------------------------
// tb_mlfq_slice_scheduler
// Self-checking bench for the three-level feedback queue scheduler. A local
// predictor tracks the process table, the level queues, the quanta and the
// scheduler clock, and every result is compared field by field with it. The
// tests cover basic admit and run behavior, queue overflow, random traffic
// under several quantum settings, and runs of full-length slices.
// ----------------------------------------------------------------------------
module tb_mlfq_slice_scheduler;
  import mlfq_pkg::*;

  localparam logic [LVL_W-1:0] OVER_LEVEL  = 2'd3;
  localparam int               CYCLE_LIMIT = 3_000_000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic in_command;
  logic [1:0] in_level;
  logic [PID_W-1:0] in_pid;
  logic [TIME_W-1:0] in_arrival_time;
  logic [BURST_W-1:0] in_burst_time;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [Q_W-1:0] cfg_data;
  logic out_valid;
  logic [1:0] out_status;
  logic [PID_W-1:0] out_run_pid;
  logic [BURST_W-1:0] out_slice_length;
  logic [BURST_W-1:0] out_left_time;
  logic [TIME_W-1:0] out_first_start;
  logic out_done_res;
  logic [TIME_W-1:0] out_finish_stamp;
  logic signed [SPAN_W-1:0] out_response_delay;
  logic signed [SPAN_W-1:0] out_turnaround_span;
  logic signed [SPAN_W-1:0] out_waiting_span;
  logic [LVL_W-1:0] out_next_level;

  mlfq_slice_scheduler dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_command          (in_command),
    .in_level            (in_level),
    .in_pid              (in_pid),
    .in_arrival_time     (in_arrival_time),
    .in_burst_time       (in_burst_time),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_run_pid         (out_run_pid),
    .out_slice_length    (out_slice_length),
    .out_left_time       (out_left_time),
    .out_first_start     (out_first_start),
    .out_done_res        (out_done_res),
    .out_finish_stamp    (out_finish_stamp),
    .out_response_delay  (out_response_delay),
    .out_turnaround_span (out_turnaround_span),
    .out_waiting_span    (out_waiting_span),
    .out_next_level      (out_next_level)
  );

  // Predicted scheduler state.
  logic [TIME_W-1:0]  sched_clock = '0;
  logic [Q_W-1:0]     slice_quantum [NUM_LEVELS] = '{Q0_RESET, Q1_RESET, Q2_RESET};
  logic [TIME_W-1:0]  proc_arrival [MAX_PROCS];
  logic [BURST_W-1:0] proc_burst [MAX_PROCS];
  logic [BURST_W-1:0] proc_left [MAX_PROCS];
  logic [TIME_W-1:0]  proc_start [MAX_PROCS];
  bit                 proc_started [MAX_PROCS];
  logic [PID_W-1:0]   level_q [NUM_LEVELS][MAX_PROCS];
  int                 level_head [NUM_LEVELS] = '{0, 0, 0};
  int                 level_cnt [NUM_LEVELS] = '{0, 0, 0};

  result_t pending_outcomes[$];
  int      mismatch_cnt = 0;
  int      cycle_cnt = 0;
  bit      idle_en = 1'b1;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic void push_level(int lv, logic [PID_W-1:0] slot);
    if (level_cnt[lv] < MAX_PROCS) begin
      level_q[lv][(level_head[lv] + level_cnt[lv]) % MAX_PROCS] = slot;
      level_cnt[lv]++;
    end
  endfunction

  // Applies one item to the predicted state and returns the expected result.
  function automatic result_t schedule_item(cmd_e_t cmd, logic [1:0] lvl_in,
                                            logic [PID_W-1:0] pid,
                                            logic [TIME_W-1:0] arr,
                                            logic [BURST_W-1:0] burst);
    result_t res;
    int lv;
    int slot;
    int nl;
    logic [Q_W-1:0] qnt;
    logic [BURST_W-1:0] sl;
    longint clk_sum;
    longint resp;
    longint turn;
    longint idle_span;
    res = '0;
    lv = (lvl_in > LAST_LEVEL) ? LAST_LEVEL : lvl_in;
    if (cmd == CMD_ADMIT) begin
      slot = pid;
      proc_arrival[slot] = arr;
      proc_burst[slot] = burst;
      proc_left[slot] = burst;
      proc_start[slot] = '0;
      proc_started[slot] = 1'b0;
      push_level(lv, pid);
      res.status = STAT_ADMITTED;
      res.run_pid = pid;
      res.left_time = burst;
      res.finish_stamp = sched_clock;
      res.next_level = LVL_W'(lv);
    end else if (level_cnt[lv] == 0) begin
      res.status = STAT_EMPTY;
      res.finish_stamp = sched_clock;
    end else begin
      slot = level_q[lv][level_head[lv]];
      level_head[lv] = (level_head[lv] + 1) % MAX_PROCS;
      level_cnt[lv]--;
      qnt = slice_quantum[lv];
      if (!proc_started[slot]) begin
        proc_started[slot] = 1'b1;
        proc_start[slot] = sched_clock;
      end
      sl = (proc_left[slot] < qnt) ? proc_left[slot] : qnt;
      proc_left[slot] = proc_left[slot] - sl;
      clk_sum = longint'(sched_clock) + longint'(sl);
      sched_clock = (clk_sum > longint'(CLOCK_MAX)) ? CLOCK_MAX : TIME_W'(clk_sum);
      res.status = STAT_RAN;
      res.run_pid = PID_W'(slot);
      res.slice_length = sl;
      res.left_time = proc_left[slot];
      res.first_start = proc_start[slot];
      res.finish_stamp = sched_clock;
      if (proc_left[slot] == 0) begin
        resp = longint'(proc_start[slot]) - longint'(proc_arrival[slot]);
        turn = longint'(sched_clock) - longint'(proc_arrival[slot]);
        idle_span = turn - longint'(proc_burst[slot]);
        if (idle_span < -64'sd2147483648) idle_span = -64'sd2147483648;
        res.done_res = 1'b1;
        res.response_delay = resp[31:0];
        res.turnaround_span = turn[31:0];
        res.waiting_span = idle_span[31:0];
      end else begin
        // A full quantum demotes, except on the last level.
        nl = (sl == qnt && lv < LAST_LEVEL) ? lv + 1 : lv;
        push_level(nl, PID_W'(slot));
        res.next_level = LVL_W'(nl);
      end
    end
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk) begin : result_check
    result_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_outcomes.size() == 0) begin
        $error("result with no item waiting: status %0d pid %0d", out_status, out_run_pid);
        mismatch_cnt++;
      end else begin
        exp_r = pending_outcomes.pop_front();
        check_field("status", exp_r.status, out_status);
        check_field("run_pid", exp_r.run_pid, out_run_pid);
        check_field("slice_length", exp_r.slice_length, out_slice_length);
        check_field("left_time", exp_r.left_time, out_left_time);
        check_field("first_start", exp_r.first_start, out_first_start);
        check_field("done_res", exp_r.done_res, out_done_res);
        check_field("finish_stamp", exp_r.finish_stamp, out_finish_stamp);
        check_field("response_delay", exp_r.response_delay, out_response_delay);
        check_field("turnaround_span", exp_r.turnaround_span, out_turnaround_span);
        check_field("waiting_span", exp_r.waiting_span, out_waiting_span);
        check_field("next_level", exp_r.next_level, out_next_level);
      end
    end
  end

  task automatic send_item(cmd_e_t cmd, logic [1:0] lvl, logic [PID_W-1:0] pid,
                           logic [TIME_W-1:0] arr, logic [BURST_W-1:0] burst);
    int gap;
    if (idle_en && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 4);
      repeat (gap) begin
        @(negedge clk);
        start = 1'b0;
        in_command = 1'($urandom);
        in_pid = PID_W'($urandom);
        in_arrival_time = TIME_W'($urandom);
        in_burst_time = BURST_W'($urandom);
      end
    end
    @(negedge clk);
    start = 1'b1;
    in_command = cmd;
    in_level = lvl;
    in_pid = pid;
    in_arrival_time = arr;
    in_burst_time = burst;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_outcomes.push_back(schedule_item(cmd, lvl, pid, arr, burst));
  endtask

  task automatic run_level(logic [1:0] lvl);
    send_item(CMD_RUN, lvl, PID_W'($urandom), TIME_W'($urandom), BURST_W'($urandom));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic write_quanta(logic [Q_W-1:0] q0, logic [Q_W-1:0] q1, logic [Q_W-1:0] q2);
    logic [Q_W-1:0] vals [NUM_LEVELS];
    vals = '{q0, q1, q2};
    wait_idle();
    for (int k = 0; k < NUM_LEVELS; k++) begin
      @(negedge clk);
      cfg_valid = 1'b1;
      cfg_index = cfg_reg_e_t'(k);
      cfg_data = vals[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      slice_quantum[k] = vals[k];
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_directed_basics();
    run_level(2'd0);
    run_level(OVER_LEVEL);
    send_item(CMD_ADMIT, 2'd0, 6'd63, 31'd0, 16'd5);
    send_item(CMD_ADMIT, OVER_LEVEL, 6'd0, CLOCK_MAX, 16'd1);
    send_item(CMD_ADMIT, 2'd1, 6'd21, 31'h5555_5555, 16'd0);
    run_level(2'd0);
    // The zero burst process finishes on its first slice.
    run_level(2'd1);
    run_level(2'd1);
    // Arrival lies far ahead of the clock, so the spans go negative.
    run_level(OVER_LEVEL);
    run_level(2'd2);
    write_quanta(16'd0, 16'hFFFF, 16'd1);
    send_item(CMD_ADMIT, 2'd0, 6'd42, 31'h2AAA_AAAA, 16'hFFFF);
    // A zero quantum gives an empty slice that still counts as a full one.
    run_level(2'd0);
    run_level(2'd1);
    send_item(CMD_ADMIT, 2'd2, 6'd9, 31'd3, 16'd3);
    repeat (3) run_level(2'd2);
  endtask

  task automatic test_fifo_overflow();
    write_quanta(16'd2, 16'd4, 16'd8);
    for (int i = 0; i < MAX_PROCS; i++)
      send_item(CMD_ADMIT, 2'd1, PID_W'(i), TIME_W'($urandom), 16'd6);
    // Level 1 is full: the table entry is rewritten but nothing is queued.
    send_item(CMD_ADMIT, 2'd1, 6'd0, 31'd10, 16'd7);
    send_item(CMD_ADMIT, 2'd0, 6'd5, 31'd20, 16'd50);
    // The demotion lands on the full level and the process is dropped.
    run_level(2'd0);
    for (int i = 0; i < MAX_PROCS; i++) run_level(2'd1);
    while (level_cnt[2] != 0) run_level(2'd2);
    run_level(2'd2);
  endtask

  task automatic test_random_traffic();
    logic [Q_W-1:0] qv [NUM_LEVELS];
    logic [1:0] lvl;
    logic [TIME_W-1:0] arr;
    logic [BURST_W-1:0] burst;
    int pick;
    for (int phase = 0; phase < 5; phase++) begin
      for (int k = 0; k < NUM_LEVELS; k++) begin
        case ($urandom_range(0, 5))
          0: qv[k] = 16'd0;
          1: qv[k] = 16'd1;
          2: qv[k] = 16'hFFFF;
          default: qv[k] = Q_W'($urandom_range(1, 12));
        endcase
      end
      write_quanta(qv[0], qv[1], qv[2]);
      for (int n = 0; n < 170; n++) begin
        if ($urandom_range(0, 99) < 55) begin
          lvl = 2'($urandom_range(0, 3));
          // Mostly run a level that has work queued.
          if ($urandom_range(0, 4) != 0 && (level_cnt[0] + level_cnt[1] + level_cnt[2]) != 0)
            do lvl = 2'($urandom_range(0, 2)); while (level_cnt[lvl] == 0);
          run_level(lvl);
        end else begin
          case ($urandom_range(0, 3))
            0: arr = TIME_W'($urandom);
            1: arr = sched_clock + TIME_W'($urandom_range(0, 50));
            default: arr = (sched_clock > 200) ? sched_clock - TIME_W'($urandom_range(0, 200))
                                               : TIME_W'($urandom_range(0, 200));
          endcase
          pick = $urandom_range(0, 99);
          if (pick < 8) burst = '0;
          else if (pick < 16) burst = BURST_W'($urandom);
          else burst = BURST_W'($urandom_range(1, 24));
          send_item(CMD_ADMIT, 2'($urandom_range(0, 3)), PID_W'($urandom), arr, burst);
        end
      end
    end
  endtask

  task automatic test_long_slices();
    idle_en = 1'b0;
    write_quanta(16'hFFFF, 16'hFFFF, 16'hFFFF);
    for (int lv = 0; lv < NUM_LEVELS; lv++)
      while (level_cnt[lv] != 0) run_level(2'(lv));
    // Full-length slices move the clock far beyond the range of one slice.
    for (int i = 0; i < 24; i++) begin
      send_item(CMD_ADMIT, LAST_LEVEL, PID_W'(i), TIME_W'($urandom), 16'hFFFF);
      run_level(LAST_LEVEL);
    end
    send_item(CMD_ADMIT, 2'd0, 6'd63, CLOCK_MAX, 16'd300);
    run_level(2'd0);
    run_level(2'd0);
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_command = CMD_ADMIT;
    in_level = '0;
    in_pid = '0;
    in_arrival_time = '0;
    in_burst_time = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_QUANTUM0;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_basics();
    test_fifo_overflow();
    test_random_traffic();
    test_long_slices();

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
